// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; clocked on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge out of reset.
`define HFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge out of reset.
`define HFE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== src/hfe_pkg.sv =====
package hfe_pkg;

  // Widths of the fixed-point formats
  localparam int unsigned X_W   = 32;   // x, Q8.24
  localparam int unsigned P_W   = 64;   // p values, Q32.32
  localparam int unsigned C_W   = 32;   // coefficients and k magnitudes
  localparam int unsigned K_W   = 33;   // k = x*sqrt(2/i), signed, |k| < 2^32
  localparam int unsigned ACC_W = 97;   // 32x64 magnitude product plus rounding

  localparam int unsigned MAX_DEGREE_DEF = 15;

  // Start value pi^-1/4 in Q32.32 and pi^(1/4) in Q2.30
  localparam logic [P_W-1:0] P0_Q32         = 64'd3226059649;
  localparam logic [C_W-1:0] PI_QUARTER_Q30 = 32'd1429510462;

  localparam logic [P_W-1:0] P_MAX = {1'b0, {(P_W-1){1'b1}}};
  localparam logic [P_W-1:0] P_MIN = {1'b1, {(P_W-1){1'b0}}};

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd1;

  // Micro-operations of the sequencer
  typedef enum logic [3:0] {
    OP_WAIT,    // take a request, set up the recurrence
    OP_LOAD,    // latch operand magnitudes and sign, preset rounding
    OP_PP_LO,   // accumulate a * b[31:0]
    OP_PP_HI,   // accumulate a * b[63:32] << 32
    OP_SAT,     // shift, saturate, apply sign, write destination
    OP_SUB,     // p_i = t1 - t2 with saturation, shift history
    OP_NEXT,    // loop on degree index
    OP_MODE,    // skip scaling in normalized mode
    OP_SKIPZ,   // skip scale loop for degree zero
    OP_OUT      // hand result to output register
  } op_e;

  typedef enum logic [2:0] {
    SRC_K,      // sqrt(2/i) * x
    SRC_T1,     // k * p_{i-1}
    SRC_T2,     // sqrt((i-1)/i) * p_{i-2}
    SRC_PI,     // pi^(1/4) * p_n
    SRC_S       // sqrt(2i) * p
  } src_e;

  typedef enum logic [1:0] {
    DST_K,
    DST_T1,
    DST_T2,
    DST_CUR
  } dst_e;

  typedef enum logic [1:0] {
    SHF_24,
    SHF_28,
    SHF_30
  } shf_e;

  localparam int unsigned NUM_STEPS = 27;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT  = 5'd0;
  localparam step_t STEP_LOOP  = 5'd1;
  localparam step_t STEP_MODE  = 5'd15;
  localparam step_t STEP_SCALE = 5'd21;
  localparam step_t STEP_OUT   = 5'd26;
  localparam step_t STEP_LAST  = 5'd26;

  typedef struct packed {
    op_e   op;
    src_e  src;
    dst_e  dst;
    shf_e  shf;
    step_t tgt;
  } ctrl_t;

  // Control store: one word per step
  localparam ctrl_t UCODE [NUM_STEPS] = '{
    '{OP_WAIT,  SRC_K,  DST_K,   SHF_30, STEP_MODE},   // 0
    '{OP_LOAD,  SRC_K,  DST_K,   SHF_30, STEP_WAIT},   // 1  k = x*A[i]
    '{OP_PP_LO, SRC_K,  DST_K,   SHF_30, STEP_WAIT},
    '{OP_PP_HI, SRC_K,  DST_K,   SHF_30, STEP_WAIT},
    '{OP_SAT,   SRC_K,  DST_K,   SHF_30, STEP_WAIT},
    '{OP_LOAD,  SRC_T1, DST_T1,  SHF_24, STEP_WAIT},   // 5  t1 = k*cur
    '{OP_PP_LO, SRC_T1, DST_T1,  SHF_24, STEP_WAIT},
    '{OP_PP_HI, SRC_T1, DST_T1,  SHF_24, STEP_WAIT},
    '{OP_SAT,   SRC_T1, DST_T1,  SHF_24, STEP_WAIT},
    '{OP_LOAD,  SRC_T2, DST_T2,  SHF_30, STEP_WAIT},   // 9  t2 = B[i]*prev
    '{OP_PP_LO, SRC_T2, DST_T2,  SHF_30, STEP_WAIT},
    '{OP_PP_HI, SRC_T2, DST_T2,  SHF_30, STEP_WAIT},
    '{OP_SAT,   SRC_T2, DST_T2,  SHF_30, STEP_WAIT},
    '{OP_SUB,   SRC_K,  DST_CUR, SHF_30, STEP_WAIT},   // 13
    '{OP_NEXT,  SRC_K,  DST_CUR, SHF_30, STEP_LOOP},   // 14
    '{OP_MODE,  SRC_K,  DST_CUR, SHF_30, STEP_OUT},    // 15
    '{OP_LOAD,  SRC_PI, DST_CUR, SHF_30, STEP_WAIT},   // 16 cur *= pi^(1/4)
    '{OP_PP_LO, SRC_PI, DST_CUR, SHF_30, STEP_WAIT},
    '{OP_PP_HI, SRC_PI, DST_CUR, SHF_30, STEP_WAIT},
    '{OP_SAT,   SRC_PI, DST_CUR, SHF_30, STEP_WAIT},
    '{OP_SKIPZ, SRC_K,  DST_CUR, SHF_30, STEP_OUT},    // 20
    '{OP_LOAD,  SRC_S,  DST_CUR, SHF_28, STEP_WAIT},   // 21 cur *= S[i]
    '{OP_PP_LO, SRC_S,  DST_CUR, SHF_28, STEP_WAIT},
    '{OP_PP_HI, SRC_S,  DST_CUR, SHF_28, STEP_WAIT},
    '{OP_SAT,   SRC_S,  DST_CUR, SHF_28, STEP_WAIT},
    '{OP_NEXT,  SRC_K,  DST_CUR, SHF_28, STEP_SCALE},  // 25
    '{OP_OUT,   SRC_K,  DST_CUR, SHF_30, STEP_WAIT}    // 26
  };

  // Integer square root; only evaluated on constants when the ROMs are built
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

endpackage

// ===== src/hermite_function_eval.sv =====
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o   x_value_i (Q8.24)
// result    out        out_valid_o / out_stall_i poly_value_o (Q32.32), overflow_flag_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// in_stall_o stays high from a taken request until its result appears and drops in
// the cycle the result appears, so the sequencer works on one request at a time.
// Normalized mode skips the scaling steps that standard mode runs.
// Each product goes through the single 32x32 multiplier as two partial products,
// four control steps per product, and a degree step needs three products.
// Reset clears the sequencer, the degree and mode registers and the output valid.
// A result held by out_stall_i does not block the next request; the sequencer
// waits in its output step only when the previous result is still pending.
`include "assert_macros.svh"

module hermite_function_eval
  import hfe_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [X_W-1:0]        x_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [P_W-1:0]        poly_value_o,
  output logic                  overflow_flag_o
);

  localparam int unsigned IW = $clog2(MAX_DEGREE + 1);

  // Configuration registers
  logic [3:0] degree_q;
  logic       mode_q;

  // Sequencer
  step_t   pc_q, pc_d;
  ctrl_t   ctl;
  logic [IW-1:0] i_q, n_q, n_clamp;

  // Datapath
  logic [X_W-1:0]   x_q;
  logic [P_W-1:0]   cur_q, prev_q, t1_q, t2_q;
  logic [K_W-1:0]   k_q, k_abs;
  logic [C_W-1:0]   a_mag_q, a_mag_d;
  logic [P_W-1:0]   b_mag_q, b_mag_d, b_val;
  logic             a_sgn, neg_q;
  logic [ACC_W-1:0] acc_q, addend, rnd, q_shift;
  logic [C_W-1:0]   mul_b;
  logic [2*C_W-1:0] prod;
  logic [4:0]       sh_amt;
  logic [P_W-1:0]   limit, sat_mag, sat_res;
  logic             sat_ovf;
  logic [P_W:0]     diff;
  logic [P_W-1:0]   sub_res;
  logic             sub_ovf;
  logic             ovf_q;

  // Output register
  logic             out_valid_q, out_ovf_q;
  logic [P_W-1:0]   out_poly_q;

  logic in_acc, out_acc, out_free;

  // Coefficient ROMs, built at elaboration
  logic [C_W-1:0] rom_a [MAX_DEGREE+1];
  logic [C_W-1:0] rom_b [MAX_DEGREE+1];
  logic [C_W-1:0] rom_s [MAX_DEGREE+1];

  for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_coef
    if (g == 0) begin : g_zero
      assign rom_a[g] = '0;
      assign rom_b[g] = '0;
      assign rom_s[g] = '0;
    end else begin : g_entry
      localparam logic [63:0] ArgA = (64'd1 << 61) / 64'(g);
      localparam logic [63:0] ArgB = ((64'd1 << 60) / 64'(g)) * 64'(g - 1);
      localparam logic [63:0] ArgS = 64'(2 * g) << 56;
      assign rom_a[g] = C_W'(isqrt64(ArgA));
      assign rom_b[g] = C_W'(isqrt64(ArgB));
      assign rom_s[g] = C_W'(isqrt64(ArgS));
    end
  end

  assign ctl      = UCODE[pc_q];
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o      = (pc_q != STEP_WAIT);
  assign out_valid_o     = out_valid_q;
  assign poly_value_o    = out_poly_q;
  assign overflow_flag_o = out_ovf_q;

  // Degree clamped to the table size
  always_comb begin
    if (32'(degree_q) > MAX_DEGREE) begin
      n_clamp = IW'(MAX_DEGREE);
    end else begin
      n_clamp = IW'(degree_q);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEGREE: degree_q <= cfg_wdata_i;
        CFG_MODE:   mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Next step
  always_comb begin
    pc_d = pc_q + step_t'(1);
    unique case (ctl.op)
      OP_WAIT: begin
        if (!in_acc) begin
          pc_d = pc_q;
        end else if (n_clamp == '0) begin
          pc_d = ctl.tgt;
        end
      end
      OP_NEXT: begin
        if (i_q != n_q) pc_d = ctl.tgt;
      end
      OP_MODE: begin
        if (!mode_q) pc_d = ctl.tgt;
      end
      OP_SKIPZ: begin
        if (n_q == '0) pc_d = ctl.tgt;
      end
      OP_OUT: begin
        pc_d = out_free ? STEP_WAIT : pc_q;
      end
      default: ;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
      i_q  <= IW'(1);
      n_q  <= '0;
    end else begin
      pc_q <= pc_d;
      if (ctl.op == OP_WAIT && in_acc) begin
        i_q <= IW'(1);
        n_q <= n_clamp;
      end else if (ctl.op == OP_NEXT) begin
        i_q <= (i_q != n_q) ? i_q + IW'(1) : IW'(1);
      end
    end
  end

  // Operand selection
  assign k_abs = k_q[K_W-1] ? (~k_q + K_W'(1)) : k_q;

  always_comb begin
    a_sgn   = 1'b0;
    a_mag_d = rom_a[i_q];
    b_val   = cur_q;
    case (ctl.src)
      SRC_K: begin
        b_val = {{(P_W-X_W){x_q[X_W-1]}}, x_q};
      end
      SRC_T1: begin
        a_sgn   = k_q[K_W-1];
        a_mag_d = k_abs[C_W-1:0];
      end
      SRC_T2: begin
        a_mag_d = rom_b[i_q];
        b_val   = prev_q;
      end
      SRC_PI: a_mag_d = PI_QUARTER_Q30;
      SRC_S:  a_mag_d = rom_s[i_q];
      default: ;
    endcase
    b_mag_d = b_val[P_W-1] ? (~b_val + P_W'(1)) : b_val;
  end

  // Binary point of the current product
  always_comb begin
    unique case (ctl.shf)
      SHF_24:  sh_amt = 5'd24;
      SHF_28:  sh_amt = 5'd28;
      SHF_30:  sh_amt = 5'd30;
      default: sh_amt = 5'd30;
    endcase
  end

  assign rnd = ACC_W'(1) << (sh_amt - 5'd1);

  // Shared 32x32 multiplier, one partial product per step
  assign mul_b  = (ctl.op == OP_PP_HI) ? b_mag_q[P_W-1:C_W] : b_mag_q[C_W-1:0];
  assign prod   = a_mag_q * mul_b;
  assign addend = (ctl.op == OP_PP_HI) ? ACC_W'({prod, {C_W{1'b0}}}) : ACC_W'(prod);

  // Scale down, saturate on magnitude, restore the sign
  always_comb begin
    q_shift = acc_q >> sh_amt;
    limit   = neg_q ? P_MIN : P_MAX;
    sat_ovf = (q_shift > ACC_W'(limit));
    sat_mag = sat_ovf ? limit : q_shift[P_W-1:0];
    sat_res = neg_q ? (~sat_mag + P_W'(1)) : sat_mag;
  end

  // Saturating difference of the recurrence
  always_comb begin
    diff    = {t1_q[P_W-1], t1_q} - {t2_q[P_W-1], t2_q};
    sub_ovf = diff[P_W] ^ diff[P_W-1];
    sub_res = sub_ovf ? (diff[P_W] ? P_MIN : P_MAX) : diff[P_W-1:0];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (ctl.op)
      OP_WAIT: begin
        if (in_acc) begin
          x_q    <= x_value_i;
          cur_q  <= P0_Q32;
          prev_q <= '0;
          ovf_q  <= 1'b0;
        end
      end
      OP_LOAD: begin
        a_mag_q <= a_mag_d;
        b_mag_q <= b_mag_d;
        neg_q   <= a_sgn ^ b_val[P_W-1];
        acc_q   <= rnd;
      end
      OP_PP_LO: begin
        acc_q <= acc_q + addend;
      end
      OP_PP_HI: begin
        acc_q <= acc_q + addend;
      end
      OP_SAT: begin
        ovf_q <= ovf_q | sat_ovf;
        case (ctl.dst)
          DST_K:   k_q   <= sat_res[K_W-1:0];
          DST_T1:  t1_q  <= sat_res;
          DST_T2:  t2_q  <= sat_res;
          default: cur_q <= sat_res;
        endcase
      end
      OP_SUB: begin
        ovf_q  <= ovf_q | sub_ovf;
        prev_q <= cur_q;
        cur_q  <= sub_res;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.op == OP_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.op == OP_OUT && out_free) begin
      out_poly_q <= cur_q;
      out_ovf_q  <= ovf_q;
    end
  end

  // Checks
  `HFE_NEVER(a_pc_range, pc_q > STEP_LAST, "step counter beyond the program")
  `HFE_ASSERT(a_idx_range,
              (pc_q != STEP_WAIT && n_q != '0) |-> (i_q != '0 && i_q <= n_q),
              "degree index outside its range")
  `HFE_ASSERT(a_req_start,
              in_acc |=> (pc_q == STEP_LOOP || pc_q == STEP_MODE),
              "request did not start the program")
  `HFE_ASSERT(a_out_src, $rose(out_valid_o) |-> $past(pc_q) == STEP_OUT,
              "result raised outside the output step")
  `HFE_ASSERT(a_out_drain, (out_acc && pc_q != STEP_OUT) |=> !out_valid_o,
              "taken result not cleared")

endmodule

// ===== test/hermite_checker.sv =====
`timescale 1ns / 1ps

// Watches the config port and the request and result channels, predicts each result
// from the current degree/scaling and compares in arrival order.
module hermite_checker
  import hfe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [X_W-1:0]        x_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [P_W-1:0]        poly_value_i,
  input  logic                  overflow_flag_i,
  output int                    pending_o,
  output int                    fail_count_o,
  output int                    checked_o,
  output int                    saturated_o
);

  localparam int unsigned TOP_DEG = MAX_DEGREE_DEF;

  typedef struct packed {
    logic [P_W-1:0] value;
    logic           sat;
  } poly_result_t;

  // Recurrence and scaling coefficients
  logic signed [63:0] rate_coef  [0:TOP_DEG];  // sqrt(2/i), Q2.30
  logic signed [63:0] damp_coef  [0:TOP_DEG];  // sqrt((i-1)/i), Q2.30
  logic signed [63:0] scale_coef [0:TOP_DEG];  // sqrt(2i), Q.28

  // Shadow of the configuration registers
  logic [3:0] deg_q;
  logic       scaled_q;

  poly_result_t expected_polys[$];
  int           fails_n;
  int           checked_n;
  int           saturated_n;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {64'd0, r | (64'd1 << b)};
      if (t * t <= {64'd0, v}) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  initial begin
    logic [63:0] iv;
    rate_coef[0]  = '0;
    damp_coef[0]  = '0;
    scale_coef[0] = '0;
    for (int i = 1; i <= TOP_DEG; i++) begin
      iv = 64'(i);
      rate_coef[i]  = floor_sqrt((64'd1 << 61) / iv);
      damp_coef[i]  = floor_sqrt(((64'd1 << 60) / iv) * (iv - 64'd1));
      scale_coef[i] = floor_sqrt((iv * 64'd2) << 56);
    end
  end

  // Exact product, shifted right by sh with round half away from zero, saturated
  function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int unsigned sh,
                                                   inout logic sat);
    logic         neg;
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] prod;
    logic [127:0] lim;
    neg  = a[63] ^ b[63];
    ua   = {64'd0, a[63] ? (~a + 64'd1) : a};
    ub   = {64'd0, b[63] ? (~b + 64'd1) : b};
    prod = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
    lim  = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
    if (prod > lim) begin
      sat  = 1'b1;
      prod = lim;
    end
    return neg ? (~prod[63:0] + 64'd1) : prod[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout logic sat);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) begin
      sat = 1'b1;
      return d[64] ? P_MIN : P_MAX;
    end
    return d[63:0];
  endfunction

  function automatic poly_result_t hermite_predict(input logic [X_W-1:0] x_raw);
    logic signed [63:0] x;
    logic signed [63:0] k;
    logic signed [63:0] t1;
    logic signed [63:0] t2;
    logic signed [63:0] cur;
    logic signed [63:0] prv;
    logic signed [63:0] nxt;
    logic               sat;
    int unsigned        n;
    poly_result_t       res;
    x   = {{32{x_raw[31]}}, x_raw};
    n   = (deg_q > TOP_DEG) ? TOP_DEG : deg_q;
    cur = P0_Q32;
    prv = '0;
    sat = 1'b0;
    // three-term recurrence
    for (int i = 1; i <= n; i++) begin
      k   = round_mul(x, rate_coef[i], 30, sat);
      t1  = round_mul(k, cur, 24, sat);
      t2  = round_mul(damp_coef[i], prv, 30, sat);
      nxt = sat_sub(t1, t2, sat);
      prv = cur;
      cur = nxt;
    end
    // physicists' scaling: pi^(1/4) * prod sqrt(2i)
    if (scaled_q) begin
      cur = round_mul(cur, {32'd0, PI_QUARTER_Q30}, 30, sat);
      for (int i = 1; i <= n; i++) cur = round_mul(cur, scale_coef[i], 28, sat);
    end
    res.value = cur;
    res.sat   = sat;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    poly_result_t want;
    if (!rst_ni) begin
      expected_polys.delete();
      deg_q        = '0;
      scaled_q     = 1'b0;
      fails_n      = 0;
      checked_n    = 0;
      saturated_n  = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
      saturated_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DEGREE) deg_q = cfg_wdata_i;
        else if (cfg_idx_i == CFG_MODE) scaled_q = cfg_wdata_i[0];
      end

      // result side first, so a stray result never meets a fresh expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_polys.size() == 0) begin
          fails_n++;
          $display("%0t: result with nothing expected, got poly %h flag %b",
                   $time, poly_value_i, overflow_flag_i);
        end else begin
          want = expected_polys.pop_front();
          checked_n++;
          if (overflow_flag_i) saturated_n++;
          if (poly_value_i !== want.value) begin
            fails_n++;
            $display("%0t: poly_value expected %h got %h",
                     $time, want.value, poly_value_i);
          end
          if (overflow_flag_i !== want.sat) begin
            fails_n++;
            $display("%0t: overflow_flag expected %b got %b",
                     $time, want.sat, overflow_flag_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i) expected_polys.push_back(hermite_predict(x_value_i));

      pending_o    <= expected_polys.size();
      fail_count_o <= fails_n;
      checked_o    <= checked_n;
      saturated_o  <= saturated_n;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hfe_pkg::*;

  localparam int unsigned     RANDOM_ITEMS = 1080;
  localparam int unsigned     QUIET_TAIL   = 100;
  localparam int unsigned     HOLD_CYCLES  = 700;
  localparam int unsigned     DRAIN_CYCLES = 320;
  localparam longint unsigned CYCLE_LIMIT  = 2000000;

  localparam logic MODE_NORMALIZED = 1'b0;
  localparam logic MODE_PHYSICIST  = 1'b1;

  localparam logic [X_W-1:0] X_ONE = 32'h0100_0000;
  localparam logic [X_W-1:0] X_MAX = 32'h7FFF_FFFF;
  localparam logic [X_W-1:0] X_MIN = 32'h8000_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [X_W-1:0]        x_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [P_W-1:0]        poly_value;
  logic                  overflow_flag;

  int pending;
  int fail_count;
  int checked;
  int saturated;
  int settings_run = 0;

  logic            hold_req = 1'b0;
  logic            quiet    = 1'b0;
  longint unsigned cycles   = 0;

  hermite_function_eval dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .x_value_i      (x_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .poly_value_o   (poly_value),
    .overflow_flag_o(overflow_flag)
  );

  hermite_checker watch (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .x_value_i      (x_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .poly_value_i   (poly_value),
    .overflow_flag_i(overflow_flag),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .checked_o      (checked),
    .saturated_o    (saturated)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: short random stalls, one long hold on request, none in the tail
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Mix of full-range, moderate and corner arguments
  function automatic logic [X_W-1:0] pick_x();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) return $urandom();
    if (sel < 14) return int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
    if (sel < 17) return int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return X_MAX;
      4:       return X_MIN;
      5:       return X_ONE;
      default: return -X_ONE;
    endcase
  endfunction

  // Offer one request and hold it until taken
  task automatic push_x(input logic [X_W-1:0] x);
    in_valid <= 1'b1;
    x_value  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Drain everything in flight, then reprogram both registers
  task automatic apply_settings(input logic [3:0] deg, input logic mode);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    write_reg(CFG_DEGREE, deg);
    write_reg(CFG_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned count;
    int unsigned phase;
    logic [3:0]  deg;
    logic        mode;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_DEGREE;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    x_value   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // degree zero: start value and its unit scaling
    apply_settings(4'd0, MODE_NORMALIZED);
    push_x('0);
    push_x(X_ONE);
    push_x(X_MAX);
    push_x(X_MIN);
    apply_settings(4'd0, MODE_PHYSICIST);
    push_x('0);
    push_x(-X_ONE);
    // first step of the recurrence
    apply_settings(4'd1, MODE_NORMALIZED);
    push_x(X_ONE);
    push_x(-X_ONE);
    push_x(X_MAX);
    // top degree, large arguments saturate
    apply_settings(4'd15, MODE_PHYSICIST);
    push_x(X_MAX);
    push_x(X_MIN);
    push_x(X_ONE);
    push_x('0);
    push_x(32'd1);
    apply_settings(4'd15, MODE_NORMALIZED);
    push_x(X_MAX);
    push_x(X_MIN);
    push_x(32'h0080_0000);
    push_x(-(X_ONE * 3));
    push_x('1);
    apply_settings(4'd5, MODE_PHYSICIST);
    push_x(X_ONE * 2);
    push_x(-(X_ONE * 2));

    // random phases, each with its own degree and scaling
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 2 || $urandom_range(0, 3) == 0) deg = 4'($urandom_range(0, 3));
      else deg = 4'($urandom_range(0, 15));
      mode = 1'($urandom_range(0, 1));
      apply_settings(deg, mode);
      count = $urandom_range(30, 90);
      for (int j = 0; j < count && sent < RANDOM_ITEMS; j++) begin
        if (RANDOM_ITEMS - sent <= QUIET_TAIL) quiet = 1'b1;
        // long result hold while requests keep coming
        if (phase == 2 && j == 2) hold_req = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push_x(pick_x());
        sent++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Compared %0d results over %0d degree/scaling settings, degrees 0 to 15.",
             checked, settings_run);
    $display("%0d results reported saturation; one long result hold filled the block.",
             saturated);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
